// ===== src/pbbd_pkg.sv =====
// Shared types, constants and control store for the per-bin beat detector.
package pbbd_pkg;

   localparam int BINS      = 8;
   localparam int IDX_W     = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int BIN_W     = 3;
   localparam int POWER_W   = 8;
   localparam int PEAK_W    = 10;
   localparam int MINI_W    = 8;
   localparam int INTEN_W   = 9;
   localparam int FRAC_W    = 12;                  // log2 fraction bits
   localparam int LOG_W     = 4 + FRAC_W;          // Q4.12
   localparam int MANT_W    = 16;                  // Q1.15 mantissa
   localparam int QUO_W     = 12;                  // quotient bits
   localparam int NUM_W     = 2 * QUO_W;           // dividend bits
   localparam int CNT_W     = 4;
   localparam int STEP_W    = 4;

   localparam logic [CNT_W-1:0]    LOOP_CNT    = CNT_W'(FRAC_W);
   localparam logic [PEAK_W-1:0]   PEAK_RESET  = PEAK_W'(3);
   localparam logic [MINI_W-1:0]   MINI_RESET  = MINI_W'(51);
   localparam logic [INTEN_W-1:0]  INTEN_FULL  = INTEN_W'(256);

   // Program steps
   localparam logic [STEP_W-1:0] STEP_FETCH = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_LOGP  = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_SQP   = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_LOGR  = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_SQR   = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_MUL   = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_DIVLD = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_DIV   = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_EMIT  = STEP_W'(8);

   typedef enum logic [1:0] {
      WAIT_NONE = 2'd0,
      WAIT_REQ  = 2'd1,
      WAIT_OUT  = 2'd2
   } wait_type;

   typedef enum logic [1:0] {
      BR_NEXT = 2'd0,
      BR_JUMP = 2'd1,
      BR_LOOP = 2'd2,
      BR_SKIP = 2'd3
   } branch_type;

   // Datapath strobes
   typedef struct packed {
      logic accept;
      logic upd;
      logic log_ld;
      logic log_src_r;
      logic sq;
      logic st_lp;
      logic st_lr;
      logic mul;
      logic div_ld;
      logic div_step;
      logic emit;
      logic cnt_ld;
   } dp_ctrl_type;

   typedef struct packed {
      dp_ctrl_type         act;
      wait_type            wt;
      branch_type          br;
      logic [STEP_W-1:0]   target;
   } ucode_word_type;

   function automatic ucode_word_type ucode(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '0;
      unique case (step)
         STEP_FETCH: begin
            w.act.accept = 1'b1;
            w.act.upd    = 1'b1;
            w.wt         = WAIT_REQ;
            w.br         = BR_SKIP;
            w.target     = STEP_EMIT;
         end
         STEP_LOGP: begin
            w.act.log_ld = 1'b1;
            w.act.cnt_ld = 1'b1;
         end
         STEP_SQP: begin
            w.act.sq = 1'b1;
            w.br     = BR_LOOP;
            w.target = STEP_SQP;
         end
         STEP_LOGR: begin
            w.act.st_lp     = 1'b1;
            w.act.log_ld    = 1'b1;
            w.act.log_src_r = 1'b1;
            w.act.cnt_ld    = 1'b1;
         end
         STEP_SQR: begin
            w.act.sq = 1'b1;
            w.br     = BR_LOOP;
            w.target = STEP_SQR;
         end
         STEP_MUL: begin
            w.act.st_lr = 1'b1;
            w.act.mul   = 1'b1;
         end
         STEP_DIVLD: begin
            w.act.div_ld = 1'b1;
            w.act.cnt_ld = 1'b1;
         end
         STEP_DIV: begin
            w.act.div_step = 1'b1;
            w.br           = BR_LOOP;
            w.target       = STEP_DIV;
         end
         STEP_EMIT: begin
            w.act.emit = 1'b1;
            w.wt       = WAIT_OUT;
            w.br       = BR_JUMP;
            w.target   = STEP_FETCH;
         end
         default: begin
            w.br     = BR_JUMP;
            w.target = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== src/pbbd_sequencer.sv =====
// Microcode sequencer: step counter, loop counter and conditional jumps.
module pbbd_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_busy,
   input  logic                  need_log,
   output logic                  req_ready,
   output pbbd_pkg::dp_ctrl_type act
);

   logic [pbbd_pkg::STEP_W-1:0] pc_ff, pc_in;
   logic [pbbd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   pbbd_pkg::ucode_word_type    word;
   logic                        stall;
   logic [pbbd_pkg::STEP_W-1:0] pc_inc;

   assign word      = pbbd_pkg::ucode(pc_ff);
   assign pc_inc    = pc_ff + pbbd_pkg::STEP_W'(1);
   assign req_ready = word.act.accept;

   always_comb begin
      unique case (word.wt)
         pbbd_pkg::WAIT_REQ: stall = !req_valid;
         pbbd_pkg::WAIT_OUT: stall = out_busy;
         default:            stall = 1'b0;
      endcase
   end

   assign act = stall ? '0 : word.act;

   always_comb begin
      pc_in = pc_ff;
      if (!stall) begin
         unique case (word.br)
            pbbd_pkg::BR_NEXT: pc_in = pc_inc;
            pbbd_pkg::BR_JUMP: pc_in = word.target;
            pbbd_pkg::BR_LOOP: pc_in = (cnt_ff != pbbd_pkg::CNT_W'(1)) ? word.target : pc_inc;
            pbbd_pkg::BR_SKIP: pc_in = need_log ? pc_inc : word.target;
         endcase
      end
   end

   always_comb begin
      priority if (act.cnt_ld) begin
         cnt_in = pbbd_pkg::LOOP_CNT;
      end else if (!stall && word.br == pbbd_pkg::BR_LOOP) begin
         cnt_in = cnt_ff - pbbd_pkg::CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= pbbd_pkg::STEP_FETCH;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   a_loop_cnt_live: assert property (@(posedge clock) disable iff (reset)
      (word.br == pbbd_pkg::BR_LOOP) |-> (cnt_ff != '0))
      else $error("loop step entered with exhausted counter");

   a_log_branch: assert property (@(posedge clock) disable iff (reset)
      (act.upd && need_log) |=> (pc_ff == pbbd_pkg::STEP_LOGP))
      else $error("beat needing log did not enter log program");

endmodule

// ===== src/pbbd_bin_state.sv =====
// Per-bin history, floor and peak average; one update per transaction.
module pbbd_bin_state (
   input  logic                          clock,
   input  logic                          reset,
   input  pbbd_pkg::dp_ctrl_type         act,
   input  logic [pbbd_pkg::BIN_W-1:0]    req_bin,
   input  logic [pbbd_pkg::POWER_W-1:0]  req_power,
   output logic                          need_log,
   output logic                          need_log_ff,
   output logic                          beat_ff,
   output logic [pbbd_pkg::BIN_W-1:0]    bin_ff,
   output logic [pbbd_pkg::POWER_W-1:0]  p_ff,
   output logic [pbbd_pkg::PEAK_W-1:0]   r_ff
);

   logic [pbbd_pkg::POWER_W-1:0] floor_ff [pbbd_pkg::BINS];
   logic [pbbd_pkg::PEAK_W-1:0]  peak_ff  [pbbd_pkg::BINS];
   logic [pbbd_pkg::POWER_W-1:0] last_ff  [pbbd_pkg::BINS];
   logic [pbbd_pkg::POWER_W-1:0] older_ff [pbbd_pkg::BINS];

   logic [pbbd_pkg::IDX_W-1:0]   idx;
   logic                         in_range;
   logic [pbbd_pkg::PEAK_W-1:0]  r0, r1;
   logic [pbbd_pkg::POWER_W-1:0] v, older, fl0, fl1, fl2;
   logic                         peak_hit, beat;
   logic [pbbd_pkg::POWER_W:0]   peak_lhs;
   logic [11:0]                  acc3;
   logic [10:0]                  beat_lhs, beat_rhs;

   assign idx      = pbbd_pkg::IDX_W'(req_bin);
   assign in_range = 32'(req_bin) < pbbd_pkg::BINS;
   assign r0       = peak_ff[idx];
   assign v        = last_ff[idx];
   assign older    = older_ff[idx];
   assign fl0      = floor_ff[idx];

   // previous power was a local peak standing clear of the current one
   assign peak_lhs = {1'b0, req_power} + {1'b0, r0[pbbd_pkg::PEAK_W-1:2]};
   assign peak_hit = (peak_lhs < {1'b0, v}) && (v > older);

   // 3r + 2v (or + v) fits 12 bits, so the quarter never exceeds 1023
   always_comb begin
      if ({2'b00, v} > r0) begin
         acc3 = 12'(r0) * 12'd3 + {3'b000, v, 1'b0};
      end else begin
         acc3 = 12'(r0) * 12'd3 + {4'b0000, v};
      end
      r1 = peak_hit ? acc3[11:2] : r0;
   end

   always_comb begin
      priority if (req_power < fl0) begin
         fl1 = req_power;
      end else if (fl0 != '0) begin
         fl1 = fl0 - pbbd_pkg::POWER_W'(1);
      end else begin
         fl1 = fl0;
      end
   end

   assign beat_lhs = {2'b00, req_power, 1'b0};
   assign beat_rhs = {2'b00, fl1, 1'b0} + {1'b0, r1};
   assign beat     = in_range && (beat_lhs > beat_rhs);
   assign fl2      = beat ? req_power : fl1;
   assign need_log = beat && (req_power > pbbd_pkg::POWER_W'(1))
                          && (r1 > pbbd_pkg::PEAK_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pbbd_pkg::BINS; i++) begin
            floor_ff[i] <= '0;
            peak_ff[i]  <= pbbd_pkg::PEAK_RESET;
            last_ff[i]  <= '0;
            older_ff[i] <= '0;
         end
         need_log_ff <= 1'b0;
         beat_ff     <= 1'b0;
      end else if (act.upd) begin
         if (in_range) begin
            floor_ff[idx] <= fl2;
            peak_ff[idx]  <= r1;
            last_ff[idx]  <= req_power;
            older_ff[idx] <= v;
         end
         need_log_ff <= need_log;
         beat_ff     <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (act.upd) begin
         bin_ff <= req_bin;
         p_ff   <= req_power;
         r_ff   <= r1;
      end
   end

endmodule

// ===== src/pbbd_arith.sv =====
// Shared log2 squaring unit, multiplier and restoring divider for intensity.
module pbbd_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  pbbd_pkg::dp_ctrl_type         act,
   input  logic [pbbd_pkg::POWER_W-1:0]  p_ff,
   input  logic [pbbd_pkg::PEAK_W-1:0]   r_ff,
   input  logic                          beat_ff,
   input  logic                          need_log_ff,
   input  logic [pbbd_pkg::MINI_W-1:0]   min_inten,
   output logic [pbbd_pkg::INTEN_W-1:0]  intensity
);

   logic [pbbd_pkg::MANT_W-1:0]  y_ff, y_in;
   logic [pbbd_pkg::FRAC_W-1:0]  frac_ff;
   logic [3:0]                   n_ff, n_in;
   logic [pbbd_pkg::LOG_W-1:0]   lp_ff, lr_ff;
   logic [pbbd_pkg::NUM_W-1:0]   num_ff;
   logic [pbbd_pkg::MANT_W-1:0]  rem_ff;
   logic [pbbd_pkg::QUO_W-1:0]   low_ff, q_ff;

   logic [pbbd_pkg::PEAK_W-1:0]  x10;
   logic [2*pbbd_pkg::MANT_W-1:0] sq_prod;
   logic [pbbd_pkg::MANT_W:0]    sq_t;
   logic [pbbd_pkg::MINI_W:0]    mul_b;
   logic [pbbd_pkg::NUM_W:0]     mul_prod;
   logic [pbbd_pkg::MANT_W:0]    div_t;
   logic                         div_ge;
   logic [11:0]                  inten_sum;

   // normalize: top set bit gives the integer part of log2
   assign x10 = act.log_src_r ? r_ff : {2'b00, p_ff};
   always_comb begin
      n_in = '0;
      for (int i = 0; i < pbbd_pkg::PEAK_W; i++) begin
         if (x10[i]) n_in = 4'(i);
      end
      y_in = {6'b000000, x10} << (4'd15 - n_in);
   end

   assign sq_prod = y_ff * y_ff;
   assign sq_t    = sq_prod[2*pbbd_pkg::MANT_W-1:15];

   assign mul_b    = 9'd256 - {1'b0, min_inten};
   assign mul_prod = lp_ff * mul_b;

   assign div_t  = {rem_ff, low_ff[pbbd_pkg::QUO_W-1]};
   assign div_ge = div_t >= {1'b0, lr_ff};

   always_ff @(posedge clock) begin
      if (act.log_ld) begin
         n_ff    <= n_in;
         y_ff    <= y_in;
         frac_ff <= '0;
      end else if (act.sq) begin
         y_ff    <= sq_t[pbbd_pkg::MANT_W] ? sq_t[pbbd_pkg::MANT_W:1]
                                           : sq_t[pbbd_pkg::MANT_W-1:0];
         frac_ff <= {frac_ff[pbbd_pkg::FRAC_W-2:0], sq_t[pbbd_pkg::MANT_W]};
      end
      if (act.st_lp) lp_ff <= {n_ff, frac_ff};
      if (act.st_lr) lr_ff <= {n_ff, frac_ff};
      if (act.mul)   num_ff <= mul_prod[pbbd_pkg::NUM_W-1:0];
      if (act.div_ld) begin
         rem_ff <= pbbd_pkg::MANT_W'(num_ff[pbbd_pkg::NUM_W-1:pbbd_pkg::QUO_W]);
         low_ff <= num_ff[pbbd_pkg::QUO_W-1:0];
         q_ff   <= '0;
      end else if (act.div_step) begin
         rem_ff <= div_ge ? pbbd_pkg::MANT_W'(div_t - {1'b0, lr_ff})
                          : div_t[pbbd_pkg::MANT_W-1:0];
         low_ff <= {low_ff[pbbd_pkg::QUO_W-2:0], 1'b0};
         q_ff   <= {q_ff[pbbd_pkg::QUO_W-2:0], div_ge};
      end
   end

   assign inten_sum = {4'b0000, min_inten} + q_ff;

   always_comb begin
      priority if (need_log_ff) begin
         intensity = (inten_sum > 12'(pbbd_pkg::INTEN_FULL)) ? pbbd_pkg::INTEN_FULL
                                                             : inten_sum[8:0];
      end else if (beat_ff) begin
         intensity = pbbd_pkg::INTEN_FULL;
      end else begin
         intensity = '0;
      end
   end

   a_mant_normal: assert property (@(posedge clock) disable iff (reset)
      $past(act.log_ld || act.sq) |-> y_ff[pbbd_pkg::MANT_W-1])
      else $error("log mantissa left normal range");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $past(act.div_step) |-> (rem_ff < lr_ff))
      else $error("divider remainder not below divisor");

endmodule

// ===== src/per_bin_beat_detector_top.sv =====
// Top level of the per-bin beat detector: sequencer, bin state, arithmetic, output register.
//
//  channel | ports                                  | direction | handshake
//  --------+----------------------------------------+-----------+-------------------
//  req     | req_bin, req_power                     | in        | req_valid/req_ready
//  rsp     | rsp_bin_out, rsp_beat, rsp_intensity   | out       | rsp_valid/rsp_ready
//  csr     | csr_min_intensity                      | in        | csr_write_en only
//
// Without log scaling the emit step, which loads the result, follows the accepting step;
// with it, two 12-step log2 squaring loops, a multiply and a 12-step restoring divide
// run between those two steps on one shared datapath.
// Reset (synchronous, active high) sets peak averages to 3, min_intensity to 51.
// Stalls: a new transaction is accepted while the last result waits; the result
// step stalls only while the result register is held by a stalled rsp side.
module per_bin_beat_detector_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pbbd_pkg::BIN_W-1:0]    req_bin,
   input  logic [pbbd_pkg::POWER_W-1:0]  req_power,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pbbd_pkg::BIN_W-1:0]    rsp_bin_out,
   output logic                          rsp_beat,
   output logic [pbbd_pkg::INTEN_W-1:0]  rsp_intensity,
   input  logic                          csr_write_en,
   input  logic [pbbd_pkg::MINI_W-1:0]   csr_min_intensity
);

   pbbd_pkg::dp_ctrl_type          act;
   logic                           need_log, need_log_ff, beat_ff;
   logic [pbbd_pkg::BIN_W-1:0]     bin_ff;
   logic [pbbd_pkg::POWER_W-1:0]   p_ff;
   logic [pbbd_pkg::PEAK_W-1:0]    r_ff;
   logic [pbbd_pkg::INTEN_W-1:0]   intensity;
   logic                           out_busy;

   // min_intensity register
   logic [pbbd_pkg::MINI_W-1:0]    min_inten_ff;

   // result register
   logic                           rsp_valid_ff;
   logic [pbbd_pkg::BIN_W-1:0]     rsp_bin_ff;
   logic                           rsp_beat_ff;
   logic [pbbd_pkg::INTEN_W-1:0]   rsp_inten_ff;

   assign out_busy = rsp_valid_ff && !rsp_ready;

   pbbd_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .need_log  (need_log),
      .req_ready (req_ready),
      .act       (act)
   );

   pbbd_bin_state u_state (
      .clock       (clock),
      .reset       (reset),
      .act         (act),
      .req_bin     (req_bin),
      .req_power   (req_power),
      .need_log    (need_log),
      .need_log_ff (need_log_ff),
      .beat_ff     (beat_ff),
      .bin_ff      (bin_ff),
      .p_ff        (p_ff),
      .r_ff        (r_ff)
   );

   pbbd_arith u_arith (
      .clock       (clock),
      .reset       (reset),
      .act         (act),
      .p_ff        (p_ff),
      .r_ff        (r_ff),
      .beat_ff     (beat_ff),
      .need_log_ff (need_log_ff),
      .min_inten   (min_inten_ff),
      .intensity   (intensity)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_inten_ff <= pbbd_pkg::MINI_RESET;
      end else if (csr_write_en) begin
         min_inten_ff <= csr_min_intensity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (act.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (act.emit) begin
         rsp_bin_ff   <= bin_ff;
         rsp_beat_ff  <= beat_ff;
         rsp_inten_ff <= intensity;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_out   = rsp_bin_ff;
   assign rsp_beat      = rsp_beat_ff;
   assign rsp_intensity = rsp_inten_ff;

   // a new result never overwrites one still waiting on the rsp side
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      act.emit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while stalled");

   // no beat means zero intensity in the delivered transaction
   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      $past(act.emit) && !rsp_beat_ff |-> (rsp_inten_ff == '0))
      else $error("intensity nonzero without beat");

endmodule
